@@ hdl/ptss_pkg.sv @@
package ptss_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TICK_MS_DEF   = 10;
	localparam int DATA_W        = 32;
	localparam int MAX_DUE       = 16;
	localparam int DUE_CNT_W     = 5;

	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_TICK     = 2'd1;
	localparam logic [1:0] CMD_DISPATCH = 2'd2;
	localparam logic [1:0] CMD_DELETE   = 2'd3;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_TICKED  = 3'd2;
	localparam logic [2:0] KIND_DUE     = 3'd3;
	localparam logic [2:0] KIND_NONE    = 3'd4;
	localparam logic [2:0] KIND_DELETED = 3'd5;

	localparam logic [7:0] PEND_MAX = 8'hFF;

	typedef struct packed {
		logic              used;
		logic [7:0]        task_id;
		logic [DATA_W-1:0] delay;
		logic [DATA_W-1:0] period;
		logic [7:0]        pending;
	} slot_rec_t;

endpackage

@@ hdl/ptss_cell.sv @@
module ptss_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  ptss_pkg::slot_rec_t d,
	output ptss_pkg::slot_rec_t q
);
	import ptss_pkg::*;

	slot_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift_en) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

@@ hdl/ptss_div.sv @@
module ptss_div #(
	parameter int DIVISOR = ptss_pkg::TICK_MS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ptss_pkg::DATA_W-1:0]   dividend,
	output logic                          busy,
	output logic [ptss_pkg::DATA_W-1:0]   quotient
);
	import ptss_pkg::*;

	localparam int              SH    = $clog2(DIVISOR);
	localparam int              PW    = 2 * DATA_W + 1;
	localparam logic [63:0]     POW_C = 64'd1 << (DATA_W + SH);
	localparam logic [DATA_W:0] MUL_C = (DATA_W+1)'(POW_C / 64'(DIVISOR) + 64'd1);

	logic [DATA_W-1:0] work_q;
	logic [DATA_W-1:0] quot_q;
	logic              busy_q;
	logic [PW-1:0]     prod;

	// Reciprocal multiply: m = floor(2^(W+SH)/d) + 1 gives x/d exactly as (x*m) >> (W+SH)
	assign prod = PW'(work_q) * PW'(MUL_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			work_q <= '0;
			quot_q <= '0;
		end else begin
			busy_q <= start;
			if (start) begin
				work_q <= dividend;
			end
			if (busy_q) begin
				quot_q <= DATA_W'(prod >> (DATA_W + SH));
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

@@ hdl/periodic_task_slot_scheduler.sv @@
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    command, task_id, delay_ms, period_ms, slot_index
// out      source     out_valid / out_ready  kind, slot, due_task, last
//
// The slot table is a ring of NUM_SLOTS cells rotated one place per cycle, unless stalled, past one
// update unit; a command takes one revolution and then posts its last transaction, and the
// next command can be taken the cycle after that post.
// Add first divides delay and period by TICK_MS with reciprocal multiplies, then scans.
// A due result blocked by a full output register stalls the ring; the post waits for it too.
// Reset clears every slot at once; no clearing pass.
module periodic_task_slot_scheduler #(
	parameter int NUM_SLOTS = ptss_pkg::NUM_SLOTS_DEF,
	parameter int TICK_MS   = ptss_pkg::TICK_MS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [7:0]                  task_id,
	input  logic [ptss_pkg::DATA_W-1:0] delay_ms,
	input  logic [ptss_pkg::DATA_W-1:0] period_ms,
	input  logic [3:0]                  slot_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  kind,
	output logic [3:0]                  slot,
	output logic [7:0]                  due_task,
	output logic                        last
);
	import ptss_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SCAN, ST_DONE} state_t;

	state_t               state_q;
	logic [1:0]           cmd_q;
	logic [7:0]           task_q;
	logic [3:0]           idx_q;
	logic [SW-1:0]        slot_q;
	logic                 found_q;
	logic [3:0]           found_slot_q;
	logic                 held_valid_q;
	logic [3:0]           held_slot_q;
	logic [7:0]           held_task_q;
	logic [DUE_CNT_W-1:0] taken_q;
	logic [7:0]           del_task_q;
	logic                 out_valid_q;
	logic [2:0]           out_kind_q;
	logic [3:0]           out_slot_q;
	logic [7:0]           out_task_q;
	logic                 out_last_q;

	slot_rec_t         chain [NUM_SLOTS];
	slot_rec_t         head;
	slot_rec_t         head_next;
	logic              step;
	logic              accept;
	logic              div_start;
	logic              div_busy_d;
	logic              div_busy_p;
	logic [DATA_W-1:0] delay_ticks;
	logic [DATA_W-1:0] period_ticks;
	logic [SW+3:0]     slot_wide;
	logic [3:0]        slot4;
	logic              idx_match;
	logic              due;
	logic              emit_mid;
	logic              out_busy;

	assign accept    = in_valid && in_ready;
	assign div_start = accept && (command == CMD_ADD);

	ptss_div #(.DIVISOR(TICK_MS)) u_div_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (delay_ms),
		.busy     (div_busy_d),
		.quotient (delay_ticks)
	);

	ptss_div #(.DIVISOR(TICK_MS)) u_div_period (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (period_ms),
		.busy     (div_busy_p),
		.quotient (period_ticks)
	);

	// Ring: each cell takes its right neighbor; the updated head wraps to the tail
	genvar gi;
	generate
		for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
			if (gi == NUM_SLOTS - 1) begin : g_tail
				ptss_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (step),
					.d        (head_next),
					.q        (chain[gi])
				);
			end else begin : g_mid
				ptss_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (step),
					.d        (chain[gi+1]),
					.q        (chain[gi])
				);
			end
		end
	endgenerate

	assign head      = chain[0];
	assign slot_wide = {4'b0, slot_q};
	assign slot4     = slot_wide[3:0];
	assign idx_match = (slot_wide == (SW+4)'(idx_q));
	assign due       = (head.pending != 8'd0) && (taken_q < DUE_CNT_W'(MAX_DUE));
	assign emit_mid  = (cmd_q == CMD_DISPATCH) && due && held_valid_q;
	assign out_busy  = out_valid_q && !out_ready;
	assign step      = (state_q == ST_SCAN) && !(emit_mid && out_busy);

	always_comb begin
		head_next = head;
		unique case (cmd_q)
			CMD_ADD: begin
				if (!head.used && !found_q) begin
					head_next.used    = 1'b1;
					head_next.task_id = task_q;
					head_next.delay   = delay_ticks;
					head_next.period  = period_ticks;
					head_next.pending = 8'd0;
				end
			end
			CMD_TICK: begin
				if (head.used) begin
					if (head.delay == '0) begin
						if (head.pending != PEND_MAX) begin
							head_next.pending = head.pending + 8'd1;
						end
						if (head.period != '0) begin
							head_next.delay = head.period;
						end
					end else begin
						head_next.delay = head.delay - 1'b1;
					end
				end
			end
			CMD_DISPATCH: begin
				if (due) begin
					head_next.pending = head.pending - 8'd1;
					// one-shot: free the slot once reported
					if (head.period == '0) begin
						head_next = '0;
					end
				end
			end
			CMD_DELETE: begin
				if (idx_match) begin
					head_next = '0;
				end
			end
			default: head_next = head;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= CMD_ADD;
			task_q       <= '0;
			idx_q        <= '0;
			slot_q       <= '0;
			found_q      <= 1'b0;
			found_slot_q <= '0;
			held_valid_q <= 1'b0;
			held_slot_q  <= '0;
			held_task_q  <= '0;
			taken_q      <= '0;
			del_task_q   <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_ADDED;
			out_slot_q   <= '0;
			out_task_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q        <= command;
						task_q       <= task_id;
						idx_q        <= slot_index;
						slot_q       <= '0;
						found_q      <= 1'b0;
						found_slot_q <= '0;
						held_valid_q <= 1'b0;
						taken_q      <= '0;
						del_task_q   <= '0;
						state_q      <= (command == CMD_ADD) ? ST_DIV : ST_SCAN;
					end
				end
				ST_DIV: begin
					if (!div_busy_d && !div_busy_p) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step) begin
						slot_q <= SW'(slot_q + 1'b1);
						if (slot_q == SW'(NUM_SLOTS - 1)) begin
							state_q <= ST_DONE;
						end
						if (cmd_q == CMD_ADD && !head.used && !found_q) begin
							found_q      <= 1'b1;
							found_slot_q <= slot4;
						end
						if (cmd_q == CMD_DISPATCH && due) begin
							held_valid_q <= 1'b1;
							held_slot_q  <= slot4;
							held_task_q  <= head.task_id;
							taken_q      <= taken_q + 1'b1;
						end
						if (cmd_q == CMD_DELETE && idx_match) begin
							del_task_q <= head.task_id;
						end
						// flush the previous due transaction; the newest stays held for last
						if (emit_mid) begin
							out_valid_q <= 1'b1;
							out_kind_q  <= KIND_DUE;
							out_slot_q  <= held_slot_q;
							out_task_q  <= held_task_q;
							out_last_q  <= 1'b0;
						end
					end
				end
				ST_DONE: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
						unique case (cmd_q)
							CMD_ADD: begin
								out_kind_q <= found_q ? KIND_ADDED : KIND_FULL;
								out_slot_q <= found_q ? found_slot_q : 4'd0;
								out_task_q <= found_q ? task_q : 8'd0;
							end
							CMD_TICK: begin
								out_kind_q <= KIND_TICKED;
								out_slot_q <= 4'd0;
								out_task_q <= 8'd0;
							end
							CMD_DISPATCH: begin
								out_kind_q <= held_valid_q ? KIND_DUE : KIND_NONE;
								out_slot_q <= held_valid_q ? held_slot_q : 4'd0;
								out_task_q <= held_valid_q ? held_task_q : 8'd0;
							end
							CMD_DELETE: begin
								out_kind_q <= KIND_DELETED;
								out_slot_q <= idx_q;
								out_task_q <= del_task_q;
							end
							default: begin
								out_kind_q <= KIND_NONE;
								out_slot_q <= 4'd0;
								out_task_q <= 8'd0;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign slot      = out_slot_q;
	assign due_task  = out_task_q;
	assign last      = out_last_q;

	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= DUE_CNT_W'(MAX_DUE))
		else $error("due count beyond dispatch limit");

	a_held_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (cmd_q == CMD_DISPATCH))
		else $error("held due transaction outside dispatch");

	a_found_add: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (cmd_q == CMD_ADD))
		else $error("free slot flag outside add");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("command accepted without starting work");

	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit_mid) |=> (out_valid_q && !out_last_q && out_kind_q == KIND_DUE))
		else $error("flushed due transaction malformed");

endmodule
